/* sv/arabic_contextual_glyph_shaper_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the glyph shaper checker
// ----------------------------------------------------------------------------
`ifndef ARABIC_CONTEXTUAL_GLYPH_SHAPER_DEFINES_SVH
`define ARABIC_CONTEXTUAL_GLYPH_SHAPER_DEFINES_SVH

// clocked check, muted while reset is high
`define ACGS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked check that also covers the reset cycles
`define ACGS_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* sv/acgs_pkg.sv */
// ----------------------------------------------------------------------------
// acgs_pkg
// Types, code constants and glyph tables for the contextual glyph shaper.
// ----------------------------------------------------------------------------
package acgs_pkg;

   // character codes with a fixed role
   localparam logic [7:0] CODE_NUL   = 8'd0;
   localparam logic [7:0] CODE_SPACE = 8'd32;

   // pair folding codes (values after the +32 offset)
   localparam logic [7:0] FOLD_OFFSET     = 8'd32;
   localparam logic [7:0] FOLD_LEAD_D8    = 8'd248;
   localparam logic [7:0] FOLD_LEAD_KAF_A = 8'd218;
   localparam logic [7:0] FOLD_LEAD_KAF_B = 8'd250;
   localparam logic [7:0] FOLD_LEAD_SPACE = 8'd32;
   localparam logic [7:0] FOLD_TEH_IN     = 8'd201;
   localparam logic [7:0] FOLD_TEH_OUT    = 8'd255;
   localparam logic [7:0] FOLD_GAF_IN     = 8'd207;
   localparam logic [7:0] FOLD_GAF_OUT    = 8'd144;
   localparam logic [7:0] FOLD_KEHEH_IN   = 8'd166;
   localparam logic [7:0] FOLD_KEHEH_OUT  = 8'd141;
   localparam logic [7:0] FOLD_NOON_OUT   = 8'd228;
   localparam logic [7:0] FOLD_YEH_IN     = 8'd172;
   localparam logic [7:0] FOLD_COMMA_OUT  = 8'd44;

   typedef struct packed {
      logic        found;
      logic [15:0] iso;
      logic [15:0] ini;
      logic [15:0] med;
      logic [15:0] fin;
   } glyph_row_type;

   // up to three UTF-8 bytes of one shaped character, byte 0 first
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      cnt;
   } glyph_out_type;

   function automatic logic [7:0] fold_pair(input logic [7:0] lead, input logic [7:0] trail);
      logic [7:0] l;
      logic [7:0] c;
      logic       kaf_row;
      l = lead + FOLD_OFFSET;
      c = trail + FOLD_OFFSET;
      kaf_row = (l == FOLD_LEAD_KAF_A) || (l == FOLD_LEAD_KAF_B);
      if ((l == FOLD_LEAD_D8) && (c == FOLD_TEH_IN)) begin
         c = FOLD_TEH_OUT;
      end
      if ((c == FOLD_GAF_IN) && kaf_row) begin
         c = FOLD_GAF_OUT;
      end else if (c == FOLD_KEHEH_IN) begin
         c = kaf_row ? FOLD_KEHEH_OUT : FOLD_NOON_OUT;
      end
      if ((c == FOLD_YEH_IN) && ((l == FOLD_LEAD_D8) || (l == FOLD_LEAD_SPACE))) begin
         c = FOLD_COMMA_OUT;
      end
      return c;
   endfunction

   // previous letter that does not join to the following one
   function automatic logic is_nonjoin(input logic [7:0] c);
      case (c)
         8'd0, 8'd32, 8'd33, 8'd40, 8'd41, 8'd44, 8'd46, 8'd58,
         8'd168, 8'd184, 8'd191, 8'd194, 8'd199, 8'd207, 8'd208,
         8'd209, 8'd210, 8'd248: is_nonjoin = 1'b1;
         default:                is_nonjoin = 1'b0;
      endcase
   endfunction

   // following code that ends a word
   function automatic logic is_term(input logic [7:0] c);
      case (c)
         8'd0, 8'd32, 8'd33, 8'd40, 8'd41, 8'd44, 8'd46, 8'd58,
         8'd191, 8'd248: is_term = 1'b1;
         default:        is_term = 1'b0;
      endcase
   endfunction

   // glyph ROM: isolated, initial, medial, final
   function automatic glyph_row_type glyph_lookup(input logic [7:0] c);
      glyph_row_type r;
      r = '0;
      case (c)
         8'd193: r = '{1'b1, 16'hFE80, 16'hFE80, 16'hFE80, 16'hFE80};
         8'd194: r = '{1'b1, 16'hFE81, 16'hFE81, 16'hFE82, 16'hFE82};
         8'd195: r = '{1'b1, 16'hFE83, 16'hFE83, 16'hFE84, 16'hFE84};
         8'd196: r = '{1'b1, 16'hFE85, 16'hFE85, 16'hFE86, 16'hFE86};
         8'd197: r = '{1'b1, 16'hFE87, 16'hFE87, 16'hFE88, 16'hFE88};
         8'd198: r = '{1'b1, 16'hFE89, 16'hFE8B, 16'hFE8C, 16'hFE8A};
         8'd199: r = '{1'b1, 16'hFE8D, 16'hFE8D, 16'hFE8E, 16'hFE8E};
         8'd200: r = '{1'b1, 16'hFE8F, 16'hFE91, 16'hFE92, 16'hFE90};
         8'd255: r = '{1'b1, 16'hFE93, 16'hFE93, 16'hFE94, 16'hFE94};
         8'd202: r = '{1'b1, 16'hFE95, 16'hFE97, 16'hFE98, 16'hFE96};
         8'd203: r = '{1'b1, 16'hFE99, 16'hFE9B, 16'hFE9C, 16'hFE9A};
         8'd204: r = '{1'b1, 16'hFE9D, 16'hFE9F, 16'hFEA0, 16'hFE9E};
         8'd205: r = '{1'b1, 16'hFEA1, 16'hFEA3, 16'hFEA4, 16'hFEA2};
         8'd206: r = '{1'b1, 16'hFEA5, 16'hFEA7, 16'hFEA8, 16'hFEA6};
         8'd207: r = '{1'b1, 16'hFEA9, 16'hFEA9, 16'hFEAA, 16'hFEAA};
         8'd208: r = '{1'b1, 16'hFEAB, 16'hFEAB, 16'hFEAC, 16'hFEAC};
         8'd209: r = '{1'b1, 16'hFEAD, 16'hFEAD, 16'hFEAE, 16'hFEAE};
         8'd210: r = '{1'b1, 16'hFEAF, 16'hFEAF, 16'hFEB0, 16'hFEB0};
         8'd184: r = '{1'b1, 16'hFB8A, 16'hFB8A, 16'hFB8B, 16'hFB8B};
         8'd211: r = '{1'b1, 16'hFEB1, 16'hFEB3, 16'hFEB4, 16'hFEB2};
         8'd212: r = '{1'b1, 16'hFEB5, 16'hFEB7, 16'hFEB8, 16'hFEB6};
         8'd213: r = '{1'b1, 16'hFEB9, 16'hFEBB, 16'hFEBC, 16'hFEBA};
         8'd214: r = '{1'b1, 16'hFEBD, 16'hFEBF, 16'hFEC0, 16'hFEBE};
         8'd215: r = '{1'b1, 16'hFEC1, 16'hFEC3, 16'hFEC4, 16'hFEC2};
         8'd216: r = '{1'b1, 16'hFEC5, 16'hFEC7, 16'hFEC8, 16'hFEC6};
         8'd217: r = '{1'b1, 16'hFEC9, 16'hFECB, 16'hFECC, 16'hFECA};
         8'd218: r = '{1'b1, 16'hFECD, 16'hFECF, 16'hFED0, 16'hFECE};
         8'd160: r = '{1'b1, 16'h0640, 16'h0640, 16'h0640, 16'h0640};
         8'd161: r = '{1'b1, 16'hFED1, 16'hFED3, 16'hFED4, 16'hFED2};
         8'd162: r = '{1'b1, 16'hFED5, 16'hFED7, 16'hFED8, 16'hFED6};
         8'd163: r = '{1'b1, 16'hFED9, 16'hFEDB, 16'hFEDC, 16'hFEDA};
         8'd164: r = '{1'b1, 16'hFEDD, 16'hFEDF, 16'hFEE0, 16'hFEDE};
         8'd165: r = '{1'b1, 16'hFEE1, 16'hFEE3, 16'hFEE4, 16'hFEE2};
         8'd228: r = '{1'b1, 16'hFEE5, 16'hFEE7, 16'hFEE8, 16'hFEE6};
         8'd167: r = '{1'b1, 16'hFEE9, 16'hFEEB, 16'hFEEC, 16'hFEEA};
         8'd168: r = '{1'b1, 16'hFEED, 16'hFEED, 16'hFEEE, 16'hFEEE};
         8'd169: r = '{1'b1, 16'hFEEF, 16'hFEEF, 16'hFEF0, 16'hFEF0};
         8'd170: r = '{1'b1, 16'hFEF1, 16'hFEF3, 16'hFEF4, 16'hFEF2};
         8'd172: r = '{1'b1, 16'hFBFC, 16'hFBFE, 16'hFBFF, 16'hFBFD};
         8'd141: r = '{1'b1, 16'hFB7A, 16'hFB7C, 16'hFB7D, 16'hFB7B};
         8'd222: r = '{1'b1, 16'hFB56, 16'hFB58, 16'hFB59, 16'hFB57};
         8'd144: r = '{1'b1, 16'hFB92, 16'hFB94, 16'hFB95, 16'hFB93};
         8'd201: r = '{1'b1, 16'hFB8E, 16'hFB90, 16'hFB91, 16'hFB8F};
         8'd32:  r = '{1'b1, 16'h0020, 16'h0020, 16'h0020, 16'h0020};
         8'd44:  r = '{1'b1, 16'h060C, 16'h060C, 16'h060C, 16'h060C};
         8'd20:  r = '{1'b1, 16'h200C, 16'h200C, 16'h200C, 16'h200C};
         8'd58:  r = '{1'b1, 16'h003A, 16'h003A, 16'h003A, 16'h003A};
         8'd187: r = '{1'b1, 16'h061B, 16'h061B, 16'h061B, 16'h061B};
         8'd46:  r = '{1'b1, 16'h002E, 16'h002E, 16'h002E, 16'h002E};
         8'd191: r = '{1'b1, 16'h061F, 16'h061F, 16'h061F, 16'h061F};
         8'd48:  r = '{1'b1, 16'h06F0, 16'h06F0, 16'h06F0, 16'h06F0};
         8'd49:  r = '{1'b1, 16'h06F1, 16'h06F1, 16'h06F1, 16'h06F1};
         8'd50:  r = '{1'b1, 16'h06F2, 16'h06F2, 16'h06F2, 16'h06F2};
         8'd51:  r = '{1'b1, 16'h06F3, 16'h06F3, 16'h06F3, 16'h06F3};
         8'd52:  r = '{1'b1, 16'h06F4, 16'h06F4, 16'h06F4, 16'h06F4};
         8'd53:  r = '{1'b1, 16'h06F5, 16'h06F5, 16'h06F5, 16'h06F5};
         8'd54:  r = '{1'b1, 16'h06F6, 16'h06F6, 16'h06F6, 16'h06F6};
         8'd55:  r = '{1'b1, 16'h06F7, 16'h06F7, 16'h06F7, 16'h06F7};
         8'd56:  r = '{1'b1, 16'h06F8, 16'h06F8, 16'h06F8, 16'h06F8};
         8'd57:  r = '{1'b1, 16'h06F9, 16'h06F9, 16'h06F9, 16'h06F9};
         8'd41:  r = '{1'b1, 16'h0028, 16'h0028, 16'h0028, 16'h0028};
         8'd40:  r = '{1'b1, 16'h0029, 16'h0029, 16'h0029, 16'h0029};
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

/* sv/acgs_glyph_enc.sv */
// ----------------------------------------------------------------------------
// acgs_glyph_enc
// Picks the contextual form of one character and encodes it as UTF-8.
// ----------------------------------------------------------------------------
module acgs_glyph_enc
   import acgs_pkg::*;
(
   input  logic          enable,
   input  logic [7:0]    code,
   input  logic [7:0]    next_code,
   input  logic [7:0]    prev_code,
   output glyph_out_type glyph,
   output logic [7:0]    prev_out
);

   glyph_row_type row;
   logic [15:0]   cp;
   logic          nj_prev;
   logic          term_next;

   always_comb begin
      row       = glyph_lookup(code);
      nj_prev   = is_nonjoin(prev_code);
      term_next = is_term(next_code);
      if (nj_prev) begin
         cp = term_next ? row.iso : row.ini;
      end else begin
         cp = term_next ? row.fin : row.med;
      end

      glyph    = '0;
      prev_out = prev_code;
      if (enable) begin
         if (!row.found) begin
            // unknown code goes out raw and leaves the context alone
            glyph.bytes[0] = code;
            glyph.cnt      = 2'd1;
         end else begin
            prev_out = code;
            if (cp < 16'h0080) begin
               glyph.bytes[0] = cp[7:0];
               glyph.cnt      = 2'd1;
            end else if (cp < 16'h0800) begin
               glyph.bytes[0] = {3'b110, cp[10:6]};
               glyph.bytes[1] = {2'b10, cp[5:0]};
               glyph.cnt      = 2'd2;
            end else begin
               glyph.bytes[0] = {4'b1110, cp[15:12]};
               glyph.bytes[1] = {2'b10, cp[11:6]};
               glyph.bytes[2] = {2'b10, cp[5:0]};
               glyph.cnt      = 2'd3;
            end
         end
      end
   end

endmodule

/* sv/arabic_contextual_glyph_shaper.sv */
// ----------------------------------------------------------------------------
// arabic_contextual_glyph_shaper
// Reshapes Persian/Arabic letters of a UTF-8 byte stream into presentation forms.
// ----------------------------------------------------------------------------
// Path: accepted bytes pass the input register, output bytes the output register.
// Throughput: one input byte per cycle while its outputs fit; a byte that
//   releases characters loads 1 to 6 bytes into the output register, sent
//   one per cycle while rsp_tready is high, so the byte serializer sets the rate.
// Reset: synchronous, active high; clears the input and output registers and
//   restores the shaping context (previous letter = space, nothing pending).
module arabic_contextual_glyph_shaper
   import acgs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_byte
   input  logic       req_tlast,   // text_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // run_last
   output logic [0:0] rsp_tuser    // [0] text_done
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_end_ff, in_end_in;

   // shaping context
   logic [7:0] prev_ff, prev_in;
   logic [7:0] pend_code_ff, pend_code_in;
   logic       pend_valid_ff, pend_valid_in;
   logic [7:0] held_lead_ff, held_lead_in;
   logic       await_ff, await_in;

   // output register
   logic       job_valid_ff, job_valid_in;
   logic [7:0] job_byte_ff [6];
   logic [2:0] job_cnt_ff, job_cnt_in;
   logic [2:0] job_idx_ff, job_idx_in;
   logic       job_done_ff, job_done_in;

   logic          have;
   logic [7:0]    code;
   logic [7:0]    pend_code_n;
   logic          pend_valid_n;
   logic          en_a, en_b;
   glyph_out_type glyph_a, glyph_b;
   logic [7:0]    prev_a, prev_b;
   logic [2:0]    total;
   logic [7:0]    job_byte_in [6];
   logic [2:0]    diff;
   logic          rsp_take;
   logic          finishing;
   logic          consume;
   logic          load;

   // ---------------------------------------------------------------- decode
   always_comb begin
      have = await_ff || !in_byte_ff[7];
      code = await_ff ? fold_pair(held_lead_ff, in_byte_ff) : in_byte_ff;
      en_a = have && pend_valid_ff;
      pend_code_n  = have ? code : pend_code_ff;
      pend_valid_n = have || pend_valid_ff;
      en_b = in_end_ff && pend_valid_n;
   end

   // held character, released now that its successor is known
   acgs_glyph_enc u_enc_a (
      .enable    (en_a),
      .code      (pend_code_ff),
      .next_code (code),
      .prev_code (prev_ff),
      .glyph     (glyph_a),
      .prev_out  (prev_a)
   );

   // end of text flushes the last character against a terminator
   acgs_glyph_enc u_enc_b (
      .enable    (en_b),
      .code      (pend_code_n),
      .next_code (CODE_NUL),
      .prev_code (prev_a),
      .glyph     (glyph_b),
      .prev_out  (prev_b)
   );

   always_comb begin
      total = {1'b0, glyph_a.cnt} + {1'b0, glyph_b.cnt};
      for (int i = 0; i < 6; i++) begin
         diff = 3'(i) - {1'b0, glyph_a.cnt};
         if (3'(i) < {1'b0, glyph_a.cnt}) begin
            job_byte_in[i] = glyph_a.bytes[i % 3];
         end else begin
            case (diff)
               3'd0:    job_byte_in[i] = glyph_b.bytes[0];
               3'd1:    job_byte_in[i] = glyph_b.bytes[1];
               3'd2:    job_byte_in[i] = glyph_b.bytes[2];
               default: job_byte_in[i] = 8'd0;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- handshake
   always_comb begin
      rsp_take  = job_valid_ff && rsp_tready;
      finishing = rsp_take && rsp_tlast;
      // items with no output retire without touching the output register
      consume   = in_valid_ff && ((total == 3'd0) || !job_valid_ff || finishing);
      load      = consume && (total != 3'd0);
      req_tready = !in_valid_ff || consume;

      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_end_in   = in_end_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_end_in   = req_tlast;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end

      prev_in       = prev_ff;
      pend_code_in  = pend_code_ff;
      pend_valid_in = pend_valid_ff;
      held_lead_in  = held_lead_ff;
      await_in      = await_ff;
      if (consume) begin
         if (in_end_ff) begin
            prev_in       = CODE_SPACE;
            pend_code_in  = CODE_NUL;
            pend_valid_in = 1'b0;
            held_lead_in  = 8'd0;
            await_in      = 1'b0;
         end else begin
            prev_in       = prev_b;
            pend_code_in  = pend_code_n;
            pend_valid_in = pend_valid_n;
            await_in      = !await_ff && in_byte_ff[7];
            held_lead_in  = await_in ? in_byte_ff : 8'd0;
         end
      end

      job_valid_in = job_valid_ff;
      job_cnt_in   = job_cnt_ff;
      job_idx_in   = job_idx_ff;
      job_done_in  = job_done_ff;
      if (load) begin
         job_valid_in = 1'b1;
         job_cnt_in   = total;
         job_idx_in   = 3'd0;
         job_done_in  = in_end_ff;
      end else if (finishing) begin
         job_valid_in = 1'b0;
      end else if (rsp_take) begin
         job_idx_in = job_idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         job_valid_ff  <= 1'b0;
         prev_ff       <= CODE_SPACE;
         pend_code_ff  <= CODE_NUL;
         pend_valid_ff <= 1'b0;
         held_lead_ff  <= 8'd0;
         await_ff      <= 1'b0;
         job_idx_ff    <= 3'd0;
         job_cnt_ff    <= 3'd0;
         job_done_ff   <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         job_valid_ff  <= job_valid_in;
         prev_ff       <= prev_in;
         pend_code_ff  <= pend_code_in;
         pend_valid_ff <= pend_valid_in;
         held_lead_ff  <= held_lead_in;
         await_ff      <= await_in;
         job_idx_ff    <= job_idx_in;
         job_cnt_ff    <= job_cnt_in;
         job_done_ff   <= job_done_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_end_ff  <= in_end_in;
      if (load) begin
         for (int i = 0; i < 6; i++) begin
            job_byte_ff[i] <= job_byte_in[i];
         end
      end
   end

   assign rsp_tvalid   = job_valid_ff;
   assign rsp_tdata    = job_byte_ff[job_idx_ff];
   assign rsp_tlast    = (job_idx_ff == (job_cnt_ff - 3'd1));
   assign rsp_tuser[0] = job_done_ff && rsp_tlast;

endmodule

/* sv/acgs_checker.sv */
// ----------------------------------------------------------------------------
// acgs_checker
// Port-level checks for the glyph shaper, bound to the top level.
// ----------------------------------------------------------------------------
`include "arabic_contextual_glyph_shaper_defines.svh"

module acgs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic [0:0] rsp_tuser
);

   // nothing comes out right after reset
   `ACGS_ASSERT_RST(a_rst_idle, reset |=> !rsp_tvalid, "output valid after reset")

   // text_done only marks the closing byte of a run
   `ACGS_ASSERT(a_done_last, rsp_tvalid && rsp_tuser[0] |-> rsp_tlast, "text_done without run_last")

   // input is only held off while output bytes are still queued
   `ACGS_ASSERT(a_bp_cause, !req_tready |-> rsp_tvalid, "input stalled with empty output")

   // a stalled output transaction keeps its contents
   `ACGS_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "stalled output changed")

endmodule

bind arabic_contextual_glyph_shaper acgs_checker u_acgs_checker (.*);
